/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is held.
`define GN3_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while reset is held.
`define GN3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Checks what a reset cycle leaves behind.
`define GN3_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

/* design/gn3_pkg.sv */
package gn3_pkg;

  localparam int TABLE_SIZE_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COORD_W        = 32;
  localparam int BYTE_W         = 8;
  localparam int N_CORNERS      = 8;
  localparam int HASH_W         = 4;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

  // Gradient selector: low four bits of the corner hash.
  typedef enum logic [3:0] {
    GR_XY_PP, GR_XY_PM, GR_XY_MP, GR_XY_MM,
    GR_XZ_PP, GR_XZ_PM, GR_XZ_MP, GR_XZ_MM,
    GR_YZ_PP, GR_YZ_PM, GR_YZ_MP, GR_YZ_MM,
    GR_XY_PP2, GR_XY_PM2, GR_XY_MP2, GR_XY_MM2
  } grad_code_t;

  // Stage tag shared by the front pipeline and the hash unit.
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [BYTE_W-1:0] index;
    logic [BYTE_W-1:0] value;
  } gn3_item_t;

endpackage

/* design/gn3_channels.sv */
interface gn3_in_if import gn3_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [BYTE_W-1:0]         table_index;
  logic [BYTE_W-1:0]         table_value;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic signed [COORD_W-1:0] z_coord;

  modport source (
    output valid, opcode, table_index, table_value, x_coord, y_coord, z_coord,
    input  ready
  );
  modport sink (
    input  valid, opcode, table_index, table_value, x_coord, y_coord, z_coord,
    output ready
  );
endinterface

interface gn3_out_if import gn3_pkg::*; #(parameter int FRAC_BITS = FRAC_BITS_DEF) ();
  logic                     valid;
  logic                     ready;
  logic signed [FRAC_BITS+1:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

/* design/gn3_hash.sv */
module gn3_hash import gn3_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  localparam int TW = $clog2(TABLE_SIZE)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            advance,
  input  gn3_item_t                       s0_item,
  input  logic [TW-1:0]                   s0_cx,
  input  logic [TW-1:0]                   s0_cy,
  input  logic [TW-1:0]                   s0_cz,
  output logic [N_CORNERS-1:0][HASH_W-1:0] hash_r
);

  typedef logic [TW-1:0] idx_t;

  // One table copy per pair of read ports; loads write each copy as they pass its stage.
  logic [BYTE_W-1:0] tab1 [TABLE_SIZE];
  logic [BYTE_W-1:0] tab2 [2][TABLE_SIZE];
  logic [BYTE_W-1:0] tab3 [4][TABLE_SIZE];

  gn3_item_t              s1_item_r, s2_item_r;
  idx_t                   s1_cy_r, s1_cz_r, s2_cz_r;
  logic [1:0][BYTE_W-1:0] p1_r;
  logic [3:0][BYTE_W-1:0] p2_r;

  idx_t             cx1;
  idx_t             w0, w1, w2;
  logic             ld0, ld1, ld2;
  logic [3:0][TW-1:0] addr2;
  logic [3:0][TW-1:0] base3;

  always_comb begin
    cx1 = s0_cx + idx_t'(1);
    w0  = idx_t'(s0_item.index);
    w1  = idx_t'(s1_item_r.index);
    w2  = idx_t'(s2_item_r.index);
    ld0 = advance && s0_item.valid && (s0_item.op == OP_LOAD);
    ld1 = advance && s1_item_r.valid && (s1_item_r.op == OP_LOAD);
    ld2 = advance && s2_item_r.valid && (s2_item_r.op == OP_LOAD);
    addr2[0] = idx_t'(p1_r[0]) + s1_cy_r;
    addr2[1] = addr2[0] + idx_t'(1);
    addr2[2] = idx_t'(p1_r[1]) + s1_cy_r;
    addr2[3] = addr2[2] + idx_t'(1);
    for (int k = 0; k < 4; k++) begin
      base3[k] = idx_t'(p2_r[k]) + s2_cz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_item_r <= '0;
      s2_item_r <= '0;
    end else if (advance) begin
      s1_item_r <= s0_item;
      s2_item_r <= s1_item_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cy_r <= s0_cy;
      s1_cz_r <= s0_cz;
      s2_cz_r <= s1_cz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld0) begin
      tab1[w0] <= s0_item.value;
    end
    if (advance) begin
      p1_r[0] <= tab1[s0_cx];
      p1_r[1] <= tab1[cx1];
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      for (int k = 0; k < 2; k++) begin
        tab2[k][w1] <= s1_item_r.value;
      end
    end
    if (advance) begin
      for (int j = 0; j < 4; j++) begin
        p2_r[j] <= tab2[j >> 1][addr2[j]];
      end
    end
  end

  // base k: AA, AB, BA, BB; corner = dx + 2*dy + 4*dz
  always_ff @(posedge clk) begin
    if (ld2) begin
      for (int k = 0; k < 4; k++) begin
        tab3[k][w2] <= s2_item_r.value;
      end
    end
    if (advance) begin
      for (int k = 0; k < 4; k++) begin
        hash_r[(k >> 1) + 2 * (k & 1)]     <= tab3[k][base3[k]][HASH_W-1:0];
        hash_r[(k >> 1) + 2 * (k & 1) + 4] <= tab3[k][base3[k] + idx_t'(1)][HASH_W-1:0];
      end
    end
  end

endmodule

/* design/gradient_noise_3d_top.sv */
// Improved 3D gradient noise, one point per clock.
// in_port carries words of two kinds. A load word (opcode 0) writes
// table_value into permutation table entry table_index; it gives no result.
// An evaluate word (opcode 1) takes signed Q16.16 x/y/z and gives one word
// on out_port: noise_value, signed Q2.16, saturated.
// Every entry a point touches must have been loaded since reset.
// Pipeline: an accepted evaluate word fills the input register, then
// passes three table lookup stages and the gradient stage, which the
// four fade multiplies run alongside, then three lerp stages and the
// output register, which drives out_port.
// Throughput: one word per cycle, loads and evaluations mixed freely;
// each lookup level has its own dual-read copies of the table and loads
// write each copy as they pass it, so lookups and loads keep their order.
// Reset clears all valid bits; the table contents stay undefined.
// When out_port stalls the whole pipeline holds and in_port.ready drops;
// no word is lost or repeated.
module gradient_noise_3d_top import gn3_pkg::*; #(
  parameter int TABLE_SIZE = TABLE_SIZE_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  gn3_in_if.sink     in_port,
  gn3_out_if.source  out_port
);

  localparam int TW = $clog2(TABLE_SIZE);
  localparam int F  = FRAC_BITS;
  localparam int FW = F + 6;
  localparam int LW = F + 5;
  localparam int GW = F + 3;
  localparam int OW = F + 2;
  localparam int NS = 8;

  typedef logic [F-1:0]         frac_t;
  typedef logic signed [FW-1:0] fix_t;
  typedef logic signed [LW-1:0] lval_t;
  typedef logic signed [GW-1:0] gval_t;
  typedef logic [TW-1:0]        cell_t;

  localparam fix_t  ONE_FX = fix_t'(2 ** F);
  localparam gval_t ONE_G  = gval_t'(2 ** F);
  localparam lval_t SAT_HI = lval_t'(2 ** (F + 1) - 1);
  localparam lval_t SAT_LO = lval_t'(-(2 ** (F + 1)));

  function automatic fix_t fmul(fix_t a, frac_t t);
    logic signed [FW+F:0] p;
    p = a * $signed({1'b0, t});
    return fix_t'(p >>> F);
  endfunction

  function automatic lval_t lerp(fix_t t, lval_t a, lval_t b);
    logic signed [LW:0]    d;
    logic signed [FW+LW:0] p;
    d = b - a;
    p = t * d;
    return a + lval_t'(p >>> F);
  endfunction

  function automatic gval_t grad(grad_code_t h, gval_t x, gval_t y, gval_t z);
    gval_t g;
    case (h) inside
      GR_XY_PP, GR_XY_PP2: g = x + y;
      GR_XY_PM, GR_XY_PM2: g = x - y;
      GR_XY_MP, GR_XY_MP2: g = y - x;
      GR_XY_MM, GR_XY_MM2: g = -x - y;
      GR_XZ_PP:            g = x + z;
      GR_XZ_PM:            g = x - z;
      GR_XZ_MP:            g = z - x;
      GR_XZ_MM:            g = -x - z;
      GR_YZ_PP:            g = y + z;
      GR_YZ_PM:            g = y - z;
      GR_YZ_MP:            g = z - y;
      default:             g = -y - z;
    endcase
    return g;
  endfunction

  logic advance;
  logic [NS:1] ev_r;
  logic        out_valid_r;

  assign out_valid_r    = ev_r[NS];
  assign advance        = !out_valid_r || out_port.ready;
  assign in_port.ready  = advance;
  assign out_port.valid = out_valid_r;

  // Input register
  gn3_item_t s0_item_r;
  cell_t     s0_cell_r [3];
  frac_t     s0_f_r    [3];

  logic signed [COORD_W-1:0]    coord [3];
  logic signed [COORD_W+TW-1:0] cext  [3];

  always_comb begin
    coord[0] = in_port.x_coord;
    coord[1] = in_port.y_coord;
    coord[2] = in_port.z_coord;
    for (int k = 0; k < 3; k++) begin
      cext[k] = (COORD_W + TW)'(coord[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_item_r <= '0;
    end else if (advance) begin
      s0_item_r.valid <= in_port.valid;
      s0_item_r.op    <= op_t'(in_port.opcode);
      s0_item_r.index <= in_port.table_index;
      s0_item_r.value <= in_port.table_value;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        s0_cell_r[k] <= cext[k][F+TW-1:F];
        s0_f_r[k]    <= coord[k][F-1:0];
      end
    end
  end

  // Evaluations only from here on; loads retire inside the hash unit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= '0;
    end else if (advance) begin
      ev_r <= {ev_r[NS-1:1], s0_item_r.valid && (s0_item_r.op == OP_EVAL)};
    end
  end

  logic [N_CORNERS-1:0][HASH_W-1:0] hash;

  gn3_hash #(.TABLE_SIZE(TABLE_SIZE)) u_hash (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .s0_item (s0_item_r),
    .s0_cx   (s0_cell_r[0]),
    .s0_cy   (s0_cell_r[1]),
    .s0_cz   (s0_cell_r[2]),
    .hash_r  (hash)
  );

  // Fade: one multiply per stage, stages 1 to 4
  fix_t  fd1_r [3], fd2_r [3], fd3_r [3];
  frac_t f1_r  [3], f2_r  [3], f3_r  [3];
  fix_t  fd0   [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      fd0[k] = (fix_t'(s0_f_r[k]) <<< 2) + (fix_t'(s0_f_r[k]) <<< 1)
               - (ONE_FX <<< 4) + ONE_FX;
    end
  end

  // Stage 4: fade outputs and corner gradients
  fix_t  u4_r, v4_r, w4_r;
  gval_t g4_r [N_CORNERS];
  gval_t off  [3][2];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      off[k][0] = gval_t'(f3_r[k]);
      off[k][1] = gval_t'(f3_r[k]) - ONE_G;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        fd1_r[k] <= fmul(fd0[k], s0_f_r[k]) + (ONE_FX <<< 3) + (ONE_FX <<< 1);
        fd2_r[k] <= fmul(fd1_r[k], f1_r[k]);
        fd3_r[k] <= fmul(fd2_r[k], f2_r[k]);
        f1_r[k]  <= s0_f_r[k];
        f2_r[k]  <= f1_r[k];
        f3_r[k]  <= f2_r[k];
      end
      u4_r <= fmul(fd3_r[0], f3_r[0]);
      v4_r <= fmul(fd3_r[1], f3_r[1]);
      w4_r <= fmul(fd3_r[2], f3_r[2]);
      for (int c = 0; c < N_CORNERS; c++) begin
        g4_r[c] <= grad(grad_code_t'(hash[c]), off[0][c & 1], off[1][(c >> 1) & 1],
                        off[2][c >> 2]);
      end
    end
  end

  // Lerp stages: along x, then y, then z
  lval_t l5_r [4];
  lval_t l6_r [2];
  lval_t r7_r;
  fix_t  v5_r, w5_r, w6_r;
  logic signed [OW-1:0] out_data_r;
  lval_t sat;

  always_comb begin
    if (r7_r > SAT_HI) begin
      sat = SAT_HI;
    end else if (r7_r < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = r7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 4; k++) begin
        l5_r[k] <= lerp(u4_r, lval_t'(g4_r[2 * k]), lval_t'(g4_r[2 * k + 1]));
      end
      v5_r <= v4_r;
      w5_r <= w4_r;
      for (int k = 0; k < 2; k++) begin
        l6_r[k] <= lerp(v5_r, l5_r[2 * k], l5_r[2 * k + 1]);
      end
      w6_r       <= w5_r;
      r7_r       <= lerp(w6_r, l6_r[0], l6_r[1]);
      out_data_r <= sat[OW-1:0];
    end
  end

  assign out_port.noise_value = out_data_r;

endmodule

/* design/gn3_checker.sv */
`include "assert_macros.svh"

module gn3_checker #(
  parameter int W = 18
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [W-1:0] out_noise
);

  `GN3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")
  `GN3_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_noise), "result word changed while stalled")
  `GN3_ASSERT_RST(a_rst_empty, !out_valid, "result valid right after reset")
  `GN3_ASSERT_SAME(a_in_open, (!out_valid || out_ready) && (in_valid || !in_valid), in_ready, "input blocked with output free")

endmodule

bind gradient_noise_3d_top gn3_checker #(.W(FRAC_BITS + 2)) u_gn3_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_port.valid),
  .in_ready  (in_port.ready),
  .out_valid (out_port.valid),
  .out_ready (out_port.ready),
  .out_noise (out_port.noise_value)
);
